// File: design/assert_macros.svh
// Assertion macros used by the checker file of the cache tag block.
// No dependencies; take in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SLC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define SLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/slc_pkg.sv
// Package for the set-associative LRU cache tag block.
// Holds widths, reset values, register indexes, the sequencer state type and the scan control struct.
`timescale 1ns / 1ps

package slc_pkg;

    // Default sizing
    localparam int SLC_MAX_LINES = 4096;
    localparam int SLC_ADDR_BITS = 26;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int LOB_W      = 3;
    localparam int SIB_W      = 3;
    localparam int LINES_W    = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINES_USED  = 2'd2;

    localparam logic [LOB_W-1:0]   LOB_RESET   = 3'd6;
    localparam logic [SIB_W-1:0]   SIB_RESET   = 3'd2;
    localparam logic [LINES_W-1:0] LINES_RESET = 13'd1024;

    // Set number is at most seven bits wide
    localparam int SET_W = 7;

    // Access counter and age stamps
    localparam int STAMP_W = 32;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_WRITE,
        ST_RESP
    } slc_state_t;

    typedef struct packed {
        logic clr;   // restart victim tracking for a new set
        logic en;    // a way's read data is present this cycle
    } slc_scan_ctl_t;

endpackage

// File: design/slc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module slc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/slc_scan.sv
// Shared compare unit for the way scan: tag match and LRU victim tracking, one way per cycle.
// Depends on slc_pkg.
`timescale 1ns / 1ps

module slc_scan #(
    parameter int ADDR_BITS = 26,
    parameter int IDX_W     = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  slc_pkg::slc_scan_ctl_t ctl,
    input  logic [ADDR_BITS-1:0]  probe_tag,
    input  logic [IDX_W-1:0]      base,
    input  logic [IDX_W-1:0]      rsp_way,
    input  logic                  rsp_vbit,
    input  logic [ADDR_BITS-1:0]  rsp_tag,
    input  logic [slc_pkg::STAMP_W-1:0] rsp_stamp,
    output logic                  hit,
    output logic [IDX_W-1:0]      victim
);
    import slc_pkg::*;

    logic               found_inv_reg;
    logic               found_inv_next;
    logic [STAMP_W-1:0] best_reg;
    logic [STAMP_W-1:0] best_next;
    logic [IDX_W-1:0]   victim_reg;
    logic [IDX_W-1:0]   victim_next;

    // Match the way just read against the probe tag
    assign hit = ctl.en && rsp_vbit && (rsp_tag == probe_tag);

    // Track first invalid way, else the oldest stamp (lowest way wins ties)
    always_comb
    begin
        found_inv_next = found_inv_reg;
        best_next      = best_reg;
        victim_next    = victim_reg;
        if (ctl.clr)
        begin
            found_inv_next = 1'b0;
            best_next      = '1;
            victim_next    = base;
        end
        else if (ctl.en && !found_inv_reg)
        begin
            if (!rsp_vbit)
            begin
                found_inv_next = 1'b1;
                victim_next    = rsp_way;
            end
            else if (rsp_stamp < best_reg)
            begin
                best_next   = rsp_stamp;
                victim_next = rsp_way;
            end
        end
    end

    assign victim = victim_next;

    // Hold tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_inv_reg <= 1'b0;
        end
        else
        begin
            found_inv_reg <= found_inv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg   <= best_next;
        victim_reg <= victim_next;
    end

endmodule

// File: design/set_assoc_lru_cache_tags.sv
// Top level of the set-associative LRU cache tag block.
// Depends on slc_pkg, slc_ram and slc_scan.
`timescale 1ns / 1ps
//
// Usage:
// - Input channel (in_valid/in_ready, byte_address): one access per item.
// - Output channel (out_valid/out_ready, hit): one result per access, in order.
// - Configuration (cfg_write, cfg_index, cfg_data): write only while idle;
//   index 0 line offset bits, 1 set index bits, 2 lines in use.
// - An accepted item passes a setup step, a scan over the ways, where
//   ways = min(lines_in_use, MAX_LINES) >> set_index_bits, with one way read
//   per cycle from the tag and stamp RAMs and registered read data, a write
//   step and a result step. A hit ends the scan early. With no ways, setup
//   goes to the result step. The next item is taken the cycle after it ends.
// - in_ready is low while an item is at work, also while a finished item
//   waits in its result step for the receiver.
// - After reset a clearing pass writes every tag entry invalid, with
//   in_ready low; configuration writes are taken meanwhile.
// - The result register frees the input side: a new item is accepted while
//   a result waits. A finished item holds in its last step until the
//   receiver takes the earlier result.
//
module set_assoc_lru_cache_tags #(
    parameter int MAX_LINES = slc_pkg::SLC_MAX_LINES,
    parameter int ADDR_BITS = slc_pkg::SLC_ADDR_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ADDR_BITS-1:0]           byte_address,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           hit,
    input  logic                           cfg_write,
    input  logic [slc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [slc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import slc_pkg::*;

    localparam int IDX_W  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int LINE_W = $clog2(MAX_LINES + 1);
    localparam int PROD_W = SET_W + LINE_W;
    localparam int TAGE_W = ADDR_BITS + 1;

    // Configuration registers
    logic [LOB_W-1:0]   lob_reg;
    logic [SIB_W-1:0]   sib_reg;
    logic [LINES_W-1:0] lines_reg;

    // Sequencer
    slc_state_t state_reg;
    slc_state_t state_next;

    // Item registers
    logic [ADDR_BITS-1:0] addr_reg;
    logic [ADDR_BITS-1:0] addr_next;
    logic [STAMP_W-1:0]   counter_reg;
    logic [STAMP_W-1:0]   counter_next;
    logic [ADDR_BITS-1:0] tag_reg;
    logic [ADDR_BITS-1:0] tag_next;
    logic [LINE_W-1:0]    ways_reg;
    logic [LINE_W-1:0]    ways_next;
    logic [IDX_W-1:0]     base_reg;
    logic [IDX_W-1:0]     base_next;
    logic [LINE_W-1:0]    rd_cnt_reg;
    logic [LINE_W-1:0]    rd_cnt_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    logic                 rsp_last_reg;
    logic                 rsp_last_next;
    logic [IDX_W-1:0]     rsp_way_reg;
    logic [IDX_W-1:0]     rsp_way_next;
    logic [IDX_W-1:0]     wr_way_reg;
    logic [IDX_W-1:0]     wr_way_next;
    logic                 hit_pend_reg;
    logic                 hit_pend_next;
    logic [IDX_W-1:0]     clr_idx_reg;
    logic [IDX_W-1:0]     clr_idx_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 hit_reg;
    logic                 hit_next;

    // Setup datapath
    logic [ADDR_BITS-1:0] block_calc;
    logic [SET_W-1:0]     set_mask;
    logic [SET_W-1:0]     set_calc;
    logic [LINE_W-1:0]    lines_calc;
    logic [LINE_W-1:0]    ways_calc;
    logic [PROD_W-1:0]    base_prod;

    // Control
    logic           accept;
    logic           issue;
    logic           slot_free;
    logic           clr_done;
    logic           scan_done;
    logic           out_load;
    slc_scan_ctl_t  scan_ctl;

    // RAM ports
    logic               tag_we;
    logic [IDX_W-1:0]   tag_waddr;
    logic [TAGE_W-1:0]  tag_wdata;
    logic               stamp_we;
    logic [IDX_W-1:0]   rd_addr;
    logic [TAGE_W-1:0]  tag_rdata;
    logic [STAMP_W-1:0] stamp_rdata;

    // Scan unit results
    logic               scan_hit;
    logic [IDX_W-1:0]   scan_victim;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lob_reg   <= LOB_RESET;
            sib_reg   <= SIB_RESET;
            lines_reg <= LINES_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_LINE_OFFSET: lob_reg   <= cfg_data[LOB_W-1:0];
                CFG_SET_INDEX:   sib_reg   <= cfg_data[SIB_W-1:0];
                CFG_LINES_USED:  lines_reg <= cfg_data[LINES_W-1:0];
                default:         ;
            endcase
        end
    end

    // Split the address into set and tag, size the set
    always_comb
    begin
        block_calc = addr_reg >> lob_reg;
        set_mask   = SET_W'((8'd1 << sib_reg) - 8'd1);
        set_calc   = block_calc[SET_W-1:0] & set_mask;
        if (32'(lines_reg) > 32'(MAX_LINES))
        begin
            lines_calc = LINE_W'(MAX_LINES);
        end
        else
        begin
            lines_calc = LINE_W'(lines_reg);
        end
        ways_calc = lines_calc >> sib_reg;
        base_prod = PROD_W'(set_calc) * PROD_W'(ways_calc);
    end

    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign clr_done  = (clr_idx_reg == IDX_W'(MAX_LINES - 1));
    assign scan_done = rsp_valid_reg && (scan_hit || rsp_last_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (ways_calc == '0)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready     = 1'b0;
        issue        = 1'b0;
        out_load     = 1'b0;
        scan_ctl.clr = 1'b0;
        scan_ctl.en  = 1'b0;
        tag_we       = 1'b0;
        stamp_we     = 1'b0;
        tag_waddr    = wr_way_reg;
        tag_wdata    = {1'b1, tag_reg};
        case (state_reg)
            ST_CLEAR:
            begin
                tag_we    = 1'b1;
                tag_waddr = clr_idx_reg;
                tag_wdata = '0;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_SETUP:
            begin
                scan_ctl.clr = 1'b1;
            end
            ST_SCAN:
            begin
                issue       = (rd_cnt_reg < ways_reg) && !scan_done;
                scan_ctl.en = rsp_valid_reg;
            end
            ST_WRITE:
            begin
                stamp_we = 1'b1;
                tag_we   = !hit_pend_reg;
            end
            ST_RESP:
            begin
                out_load = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign rd_addr = base_reg + IDX_W'(rd_cnt_reg);

    // Datapath next values
    always_comb
    begin
        addr_next      = accept ? byte_address : addr_reg;
        counter_next   = accept ? counter_reg + STAMP_W'(1) : counter_reg;
        tag_next       = tag_reg;
        ways_next      = ways_reg;
        base_next      = base_reg;
        rd_cnt_next    = rd_cnt_reg;
        wr_way_next    = wr_way_reg;
        hit_pend_next  = hit_pend_reg;
        clr_idx_next   = clr_idx_reg;
        rsp_valid_next = issue;
        rsp_last_next  = issue && (rd_cnt_reg == ways_reg - LINE_W'(1));
        rsp_way_next   = rd_addr;
        if (state_reg == ST_CLEAR)
        begin
            clr_idx_next = clr_idx_reg + IDX_W'(1);
        end
        if (state_reg == ST_SETUP)
        begin
            tag_next      = block_calc >> sib_reg;
            ways_next     = ways_calc;
            base_next     = IDX_W'(base_prod);
            rd_cnt_next   = '0;
            hit_pend_next = 1'b0;
        end
        if (issue)
        begin
            rd_cnt_next = rd_cnt_reg + LINE_W'(1);
        end
        if ((state_reg == ST_SCAN) && scan_done)
        begin
            hit_pend_next = scan_hit;
            wr_way_next   = scan_hit ? rsp_way_reg : scan_victim;
        end
        // Result register: load, or drop once taken
        out_valid_next = out_valid_reg;
        hit_next       = hit_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            hit_next       = hit_pend_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            counter_reg   <= '0;
            clr_idx_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            counter_reg   <= counter_next;
            clr_idx_reg   <= clr_idx_next;
            rsp_valid_reg <= rsp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        tag_reg      <= tag_next;
        ways_reg     <= ways_next;
        base_reg     <= base_next;
        rd_cnt_reg   <= rd_cnt_next;
        rsp_last_reg <= rsp_last_next;
        rsp_way_reg  <= rsp_way_next;
        wr_way_reg   <= wr_way_next;
        hit_pend_reg <= hit_pend_next;
        hit_reg      <= hit_next;
    end

    // Valid bit and tag per line
    slc_ram #(
        .WIDTH (TAGE_W),
        .DEPTH (MAX_LINES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .raddr (rd_addr),
        .rdata (tag_rdata)
    );

    // Age stamp per line
    slc_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (MAX_LINES)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (stamp_we),
        .waddr (wr_way_reg),
        .wdata (counter_reg),
        .raddr (rd_addr),
        .rdata (stamp_rdata)
    );

    // Shared match and victim compare
    slc_scan #(
        .ADDR_BITS (ADDR_BITS),
        .IDX_W     (IDX_W)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .probe_tag (tag_reg),
        .base      (base_next),
        .rsp_way   (rsp_way_reg),
        .rsp_vbit  (tag_rdata[TAGE_W-1]),
        .rsp_tag   (tag_rdata[ADDR_BITS-1:0]),
        .rsp_stamp (stamp_rdata),
        .hit       (scan_hit),
        .victim    (scan_victim)
    );

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;

endmodule

// File: design/slc_chk.sv
// Port-level checker for the cache tag block, bound to the top level.
// Depends on slc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slc_chk #(
    parameter int ADDR_BITS = slc_pkg::SLC_ADDR_BITS
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic [ADDR_BITS-1:0]           byte_address,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           hit,
    input logic                           cfg_write,
    input logic [slc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [slc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import slc_pkg::*;

    logic in_acc;
    logic out_stall;

    assign in_acc    = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;

    // Hold a stalled result
    `SLC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid, "result dropped under stall")
    `SLC_ASSERT_NEXT(a_hit_stable, clk, rst_n, out_stall, $stable(hit), "hit changed under stall")
    // One item at a time: busy right after an accept
    `SLC_ASSERT_NEXT(a_busy_after_acc, clk, rst_n, in_acc, !in_ready,
        "item accepted while busy")
    // A new result is loaded only from a busy cycle
    `SLC_ASSERT_SAME(a_load_when_busy, clk, rst_n, $rose(out_valid), $past(!in_ready),
        "result appeared from idle")
    // Offered items and register writes carry known values
    `SLC_ASSERT_SAME(a_known_inputs, clk, rst_n, in_valid || cfg_write,
        !$isunknown({byte_address, cfg_index, cfg_data}), "unknown value on an offered input")

endmodule

bind set_assoc_lru_cache_tags slc_chk #(
    .ADDR_BITS (ADDR_BITS)
) u_slc_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .byte_address (byte_address),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
);

// File: bench/set_assoc_lru_cache_tags_tb.sv
// Self-checking bench for set_assoc_lru_cache_tags: directed table, then random phases.
// Depends on slc_pkg and the cache tag RTL; holds its own LRU tag predictor.
`timescale 1ns / 1ps

module set_assoc_lru_cache_tags_tb;

    import slc_pkg::*;

    localparam int ADDR_W      = SLC_ADDR_BITS;
    localparam int NUM_LINES   = SLC_MAX_LINES;
    localparam int RESET_CYCLES = 12;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_CYCLES = 64;
    localparam int RUN_LIMIT   = 1000000;
    localparam int POOL_DEPTH  = 12;
    localparam int N_ROWS      = 38;

    typedef enum logic {ROW_ACCESS, ROW_CFG} row_kind_t;
    typedef enum logic [1:0] {WANT_MODEL, WANT_MISS, WANT_HIT} want_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic [ADDR_W-1:0]      addr;
        want_t                  want;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [ADDR_W-1:0]      byte_address;
    logic                   out_valid;
    logic                   out_ready;
    logic                   hit;
    logic                   cfg_write;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Predictor copy of the registers and the tag stores
    logic [LOB_W-1:0]       cur_lob = LOB_RESET;
    logic [SIB_W-1:0]       cur_sib = SIB_RESET;
    logic [LINES_W-1:0]     cur_lines = LINES_RESET;
    logic [ADDR_W-1:0]      line_tags [NUM_LINES];
    bit                     line_valid [NUM_LINES];
    logic [STAMP_W-1:0]     line_stamps [NUM_LINES];
    logic [STAMP_W-1:0]     access_count = '0;

    bit                     hits_due [$];
    logic [ADDR_W-1:0]      recent_addrs [$];
    int                     err_count = 0;
    int                     cycle_count = 0;
    int                     idle_pct = 14;
    bit                     long_hold_req = 1'b0;

    stim_row_t directed_rows [N_ROWS] = '{
        // Reset geometry: 64-byte lines, 4 sets, 1024 lines
        '{ROW_ACCESS, CFG_LINE_OFFSET, 13'd0, 26'h0000000, WANT_MISS},
        '{ROW_ACCESS, CFG_LINE_OFFSET, 13'd0, 26'h0000000, WANT_HIT},
        '{ROW_ACCESS, CFG_LINE_OFFSET, 13'd0, 26'h000003F, WANT_HIT},
        '{ROW_ACCESS, CFG_LINE_OFFSET, 13'd0, 26'h3FFFFFF, WANT_MISS},
        '{ROW_ACCESS, CFG_LINE_OFFSET, 13'd0, 26'h3FFFFC0, WANT_HIT},
        '{ROW_ACCESS, CFG_LINE_OFFSET, 13'd0, 26'h0000040, WANT_MISS},
        '{ROW_ACCESS, CFG_LINE_OFFSET, 13'd0, 26'h2AAAAAA, WANT_MODEL},
        '{ROW_ACCESS, CFG_LINE_OFFSET, 13'd0, 26'h1555555, WANT_MODEL},
        // Single line, byte granularity, fully associative
        '{ROW_CFG,    CFG_LINE_OFFSET, 13'd0, 26'h0000000, WANT_MODEL},
        '{ROW_CFG,    CFG_SET_INDEX,   13'd0, 26'h0000000, WANT_MODEL},
        '{ROW_CFG,    CFG_LINES_USED,  13'd1, 26'h0000000, WANT_MODEL},
        '{ROW_ACCESS, CFG_LINE_OFFSET, 13'd0, 26'h0000005, WANT_MODEL},
        '{ROW_ACCESS, CFG_LINE_OFFSET, 13'd0, 26'h0000005, WANT_HIT},
        '{ROW_ACCESS, CFG_LINE_OFFSET, 13'd0, 26'h0000006, WANT_MISS},
        '{ROW_ACCESS, CFG_LINE_OFFSET, 13'd0, 26'h0000005, WANT_MISS},
        // No lines at all: always a miss
        '{ROW_CFG,    CFG_LINES_USED,  13'd0, 26'h0000000, WANT_MODEL},
        '{ROW_ACCESS, CFG_LINE_OFFSET, 13'd0, 26'h0000005, WANT_MISS},
        '{ROW_ACCESS, CFG_LINE_OFFSET, 13'd0, 26'h3FFFFFF, WANT_MISS},
        // Line count above the store size, widest lines, 64 sets
        '{ROW_CFG,    CFG_LINES_USED,  13'd8191, 26'h0000000, WANT_MODEL},
        '{ROW_CFG,    CFG_SET_INDEX,   13'd6, 26'h0000000, WANT_MODEL},
        '{ROW_CFG,    CFG_LINE_OFFSET, 13'd7, 26'h0000000, WANT_MODEL},
        '{ROW_ACCESS, CFG_LINE_OFFSET, 13'd0, 26'h3FFFFFF, WANT_MODEL},
        '{ROW_ACCESS, CFG_LINE_OFFSET, 13'd0, 26'h3FFFFFF, WANT_HIT},
        // More sets than lines: no ways per set
        '{ROW_CFG,    CFG_SET_INDEX,   13'd7, 26'h0000000, WANT_MODEL},
        '{ROW_CFG,    CFG_LINES_USED,  13'd100, 26'h0000000, WANT_MODEL},
        '{ROW_ACCESS, CFG_LINE_OFFSET, 13'd0, 26'h0000000, WANT_MISS},
        // Uneven split: 8 sets of 12 ways, top set
        '{ROW_CFG,    CFG_SET_INDEX,   13'd3, 26'h0000000, WANT_MODEL},
        '{ROW_ACCESS, CFG_LINE_OFFSET, 13'd0, 26'h0000380, WANT_MODEL},
        '{ROW_ACCESS, CFG_LINE_OFFSET, 13'd0, 26'h0000380, WANT_HIT},
        // Two-way LRU, fully associative
        '{ROW_CFG,    CFG_SET_INDEX,   13'd0, 26'h0000000, WANT_MODEL},
        '{ROW_CFG,    CFG_LINES_USED,  13'd2, 26'h0000000, WANT_MODEL},
        '{ROW_CFG,    CFG_LINE_OFFSET, 13'd0, 26'h0000000, WANT_MODEL},
        '{ROW_ACCESS, CFG_LINE_OFFSET, 13'd0, 26'h0000001, WANT_MODEL},
        '{ROW_ACCESS, CFG_LINE_OFFSET, 13'd0, 26'h0000002, WANT_MODEL},
        '{ROW_ACCESS, CFG_LINE_OFFSET, 13'd0, 26'h0000001, WANT_MODEL},
        '{ROW_ACCESS, CFG_LINE_OFFSET, 13'd0, 26'h0000003, WANT_MODEL},
        '{ROW_ACCESS, CFG_LINE_OFFSET, 13'd0, 26'h0000002, WANT_MODEL},
        '{ROW_ACCESS, CFG_LINE_OFFSET, 13'd0, 26'h0000001, WANT_MODEL}
    };

    set_assoc_lru_cache_tags DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .byte_address (byte_address),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Look up one address, refresh or fill a way, return the hit flag
    function automatic bit predict_hit(input logic [ADDR_W-1:0] addr);
        logic [31:0]        blk;
        logic [31:0]        set_no;
        logic [ADDR_W-1:0]  tag;
        int                 lines;
        int                 ways;
        int                 base;
        int                 victim;
        logic [STAMP_W-1:0] best;
        int                 i;
        blk    = 32'(addr) >> cur_lob;
        set_no = blk & ((32'd1 << cur_sib) - 32'd1);
        tag    = ADDR_W'(blk >> cur_sib);
        lines  = (int'(cur_lines) > NUM_LINES) ? NUM_LINES : int'(cur_lines);
        ways   = lines >> cur_sib;
        base   = int'(set_no) * ways;
        access_count = access_count + 1'b1;
        if (ways == 0)
            return 1'b0;
        for (i = 0; i < ways; i++)
        begin
            if (line_valid[base + i] && line_tags[base + i] == tag)
            begin
                line_stamps[base + i] = access_count;
                return 1'b1;
            end
        end
        // Take the first empty way, else the oldest stamp, lowest way on ties
        victim = base;
        best   = '1;
        for (i = 0; i < ways; i++)
        begin
            if (!line_valid[base + i])
            begin
                victim = base + i;
                break;
            end
            if (line_stamps[base + i] < best)
            begin
                best   = line_stamps[base + i];
                victim = base + i;
            end
        end
        line_tags[victim]   = tag;
        line_valid[victim]  = 1'b1;
        line_stamps[victim] = access_count;
        return 1'b0;
    endfunction

    // Mostly revisit recent lines with a fresh offset, sometimes a random address
    function automatic logic [ADDR_W-1:0] next_address();
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] offset_mask;
        if (recent_addrs.size() != 0 && $urandom_range(99) < 70)
        begin
            offset_mask = ADDR_W'((32'd1 << cur_lob) - 32'd1);
            a = recent_addrs[$urandom_range(recent_addrs.size() - 1)];
            a = (a & ~offset_mask) | (ADDR_W'($urandom) & offset_mask);
        end
        else
            a = ADDR_W'($urandom);
        return a;
    endfunction

    // Offer one item, hold it until taken, then queue its predicted hit flag
    task automatic send_access(input logic [ADDR_W-1:0] addr, input want_t want);
        bit h;
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        in_valid     <= 1'b1;
        byte_address <= addr;
        do @(posedge clk); while (!in_ready);
        h = predict_hit(addr);
        hits_due.push_back(want == WANT_MODEL ? h : (want == WANT_HIT));
        recent_addrs.push_back(addr);
        if (recent_addrs.size() > POOL_DEPTH)
            void'(recent_addrs.pop_front());
    endtask

    // Drop valid and wait until every queued result has come back
    task automatic settle();
        in_valid <= 1'b0;
        while (hits_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_LINE_OFFSET: cur_lob   = data[LOB_W-1:0];
            CFG_SET_INDEX:   cur_sib   = data[SIB_W-1:0];
            CFG_LINES_USED:  cur_lines = data[LINES_W-1:0];
            default: ;
        endcase
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input int lob, input int sib, input int lines, input int n_items,
                             input int pct, input bit squeeze);
        settle();
        write_cfg(CFG_LINE_OFFSET, CFG_DATA_W'(lob));
        write_cfg(CFG_SET_INDEX, CFG_DATA_W'(sib));
        write_cfg(CFG_LINES_USED, CFG_DATA_W'(lines));
        idle_pct <= pct;
        if (squeeze)
            long_hold_req <= 1'b1;
        repeat (n_items)
            send_access(next_address(), WANT_MODEL);
    endtask

    // Stimulus
    initial
    begin
        int r;
        rst_n = 1'b0;
        in_valid     <= 1'b0;
        byte_address <= '0;
        cfg_write    <= 1'b0;
        cfg_index    <= CFG_LINE_OFFSET;
        cfg_data     <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < N_ROWS; r++)
        begin
            if (directed_rows[r].kind == ROW_CFG)
            begin
                settle();
                write_cfg(directed_rows[r].idx, directed_rows[r].data);
            end
            else
                send_access(directed_rows[r].addr, directed_rows[r].want);
        end

        run_phase(6, 2, 1024, 15, 14, 1'b0);
        run_phase($urandom_range(7), $urandom_range(7), $urandom_range(256, 1), 15, 14, 1'b0);
        // Tight LRU sets, no idling, receiver held off once
        run_phase(0, 1, 8, 20, 0, 1'b1);
        run_phase($urandom_range(7), 0, 4096, 6, 14, 1'b0);
        run_phase(3, 6, 8191, 10, 14, 1'b0);
        run_phase(2, 4, $urandom_range(8191), 10, 14, 1'b0);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Result side: check each item, stall at random, one long hold-off on request
    initial
    begin
        int hold_left;
        bit hold_used;
        bit want_hit;
        hold_left = 0;
        hold_used = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (hits_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual hit=%0b", $time, hit);
                    err_count++;
                end
                else
                begin
                    want_hit = hits_due.pop_front();
                    if (hit !== want_hit)
                    begin
                        $display("%0t: hit mismatch, expected %0b, actual %0b",
                                 $time, want_hit, hit);
                        err_count++;
                    end
                end
            end
            if (long_hold_req && !hold_used)
            begin
                hold_left = LONG_HOLD;
                hold_used = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
